[design/tvp_pkg.sv]
package tvp_pkg;

	localparam int NumW = 72;
	localparam int DvsW = 36;
	localparam int QuoW = 33;
	localparam int CellCount = QuoW;

	localparam logic [DvsW-1:0] PosDiv = 36'd1310720;
	localparam logic [30:0] ShortTMax = 31'd65;

	localparam logic [1:0] REG_VI = 2'd0;
	localparam logic [1:0] REG_D = 2'd1;
	localparam logic [1:0] REG_T = 2'd2;

	typedef enum logic [2:0] {
		SEG_NEG,
		SEG_UP,
		SEG_CRUISE,
		SEG_DOWN,
		SEG_END
	} seg_t;

	typedef enum logic [3:0] {
		VC_IDLE,
		VC_PROD,
		VC_NUM,
		VC_LOAD,
		VC_ITER,
		VC_FIN1,
		VC_FIN2,
		VC_SETTLE1,
		VC_SETTLE2
	} vc_state_t;

	typedef struct packed {
		logic [31:0] val;
		seg_t seg;
	} tag_t;

	typedef struct packed {
		logic valid;
		logic neg;
		logic big;
		logic [DvsW-1:0] rem;
		logic [QuoW-1:0] mlow;
		logic [QuoW-1:0] quo;
		logic [DvsW-1:0] dvs;
		tag_t tag;
	} div_word_t;

	typedef struct packed {
		logic valid;
		logic neg;
		logic big;
		logic [QuoW:0] quo;
		tag_t tag;
	} div_fin_t;

	// magnitude split into the part below the divisor and the bits still to shift in
	function automatic div_word_t div_prep(input logic valid, input logic [NumW-1:0] num,
			input logic [DvsW-1:0] dvs, input tag_t tag);
		div_word_t w;
		logic [NumW-1:0] mag;
		mag = num[NumW-1] ? (~num + {{(NumW-1){1'b0}}, 1'b1}) : num;
		w.valid = valid;
		w.neg = num[NumW-1];
		w.big = (mag[NumW-1:QuoW] >= {{(NumW-QuoW-DvsW){1'b0}}, dvs});
		w.rem = mag[QuoW+DvsW-1:QuoW];
		w.mlow = mag[QuoW-1:0];
		w.quo = '0;
		w.dvs = dvs;
		w.tag = tag;
		return w;
	endfunction

	// halves away from zero
	function automatic div_fin_t div_round(input div_word_t w);
		div_fin_t f;
		logic up;
		up = ({w.rem, 1'b0} >= {1'b0, w.dvs});
		f.valid = w.valid;
		f.neg = w.neg;
		f.big = w.big;
		f.quo = {1'b0, w.quo} + {{QuoW{1'b0}}, up};
		f.tag = w.tag;
		return f;
	endfunction

	function automatic logic [31:0] div_sat(input div_fin_t f);
		logic [31:0] r;
		if (f.neg) begin
			if (f.big || f.quo > 34'h0_8000_0000)
				r = 32'h8000_0000;
			else
				r = ~f.quo[31:0] + 32'd1;
		end else begin
			if (f.big || f.quo > 34'h0_7FFF_FFFF)
				r = 32'h7FFF_FFFF;
			else
				r = f.quo[31:0];
		end
		return r;
	endfunction

endpackage

[design/tvp_query_if.sv]
interface tvp_query_if;
	logic valid;
	logic ready;
	logic signed [31:0] query_time;

	modport source(output valid, output query_time, input ready);
	modport sink(input valid, input query_time, output ready);
endinterface

[design/tvp_result_if.sv]
interface tvp_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] position_ref;
	logic signed [31:0] velocity_ref;

	modport source(output valid, output position_ref, output velocity_ref, input ready);
	modport sink(input valid, input position_ref, input velocity_ref, output ready);
endinterface

[design/tvp_div_cell.sv]
module tvp_div_cell import tvp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input div_word_t word_in,
	output div_word_t word_out
);

	div_word_t data_q;
	logic valid_q;
	div_word_t nxt;
	logic [DvsW:0] trial;
	logic ge;

	// one restoring step: bring down the next dividend bit
	always_comb begin
		trial = {word_in.rem, word_in.mlow[QuoW-1]};
		ge = (trial >= {1'b0, word_in.dvs});
		nxt = word_in;
		nxt.rem = ge ? DvsW'(trial - {1'b0, word_in.dvs}) : trial[DvsW-1:0];
		nxt.mlow = {word_in.mlow[QuoW-2:0], 1'b0};
		nxt.quo = {word_in.quo[QuoW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= word_in.valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_q <= nxt;
	end

	always_comb begin
		word_out = data_q;
		word_out.valid = valid_q;
	end

endmodule

[design/tvp_div_chain.sv]
module tvp_div_chain import tvp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [NumW-1:0] num,
	input logic [DvsW-1:0] dvs,
	input tag_t tag,
	output logic out_valid,
	output logic [31:0] quot,
	output tag_t out_tag
);

	div_word_t prep_s1;
	logic prep_valid_s1;
	div_word_t link [CellCount+1];
	div_fin_t round_s35;
	logic round_valid_s35;
	logic [31:0] quot_s36;
	tag_t tag_s36;
	logic valid_s36;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_valid_s1 <= 1'b0;
			round_valid_s35 <= 1'b0;
			valid_s36 <= 1'b0;
		end else if (en) begin
			prep_valid_s1 <= in_valid;
			round_valid_s35 <= link[CellCount].valid;
			valid_s36 <= round_valid_s35;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s1 <= div_prep(1'b1, num, dvs, tag);
			round_s35 <= div_round(link[CellCount]);
			quot_s36 <= div_sat(round_s35);
			tag_s36 <= round_s35.tag;
		end
	end

	always_comb begin
		link[0] = prep_s1;
		link[0].valid = prep_valid_s1;
	end

	for (genvar i = 0; i < CellCount; i++) begin : g_cell
		tvp_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.word_in(link[i]),
			.word_out(link[i+1])
		);
	end

	assign out_valid = valid_s36;
	assign quot = quot_s36;
	assign out_tag = tag_s36;

endmodule

[design/tvp_vc_unit.sv]
module tvp_vc_unit import tvp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [31:0] travel,
	input logic [30:0] tot,
	input logic signed [63:0] tvi,
	output logic signed [31:0] vc,
	output logic busy
);

	localparam int IterSteps = QuoW - 1;
	localparam int CntW = $clog2(IterSteps);
	localparam logic [CntW-1:0] CntLast = CntW'(IterSteps - 1);

	vc_state_t state_q, state_nxt;
	logic [CntW-1:0] cnt_q;
	logic signed [NumW-1:0] num_q;
	div_fin_t fin_q;
	logic signed [31:0] vc_q;
	logic cell_en;
	logic load;
	div_word_t cell_in, cell_out;
	logic [DvsW-1:0] dvs17;
	logic signed [NumW-1:0] dist_sh;

	assign dvs17 = {1'b0, tot, 4'b0} + {5'b0, tot};
	assign dist_sh = {{(NumW-50){travel[31]}}, travel, 18'b0};

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			VC_IDLE: state_nxt = VC_IDLE;
			VC_PROD: state_nxt = VC_NUM;
			VC_NUM: state_nxt = VC_LOAD;
			VC_LOAD: state_nxt = VC_ITER;
			VC_ITER: if (cnt_q == CntLast) state_nxt = VC_FIN1;
			VC_FIN1: state_nxt = VC_FIN2;
			VC_FIN2: state_nxt = VC_SETTLE1;
			VC_SETTLE1: state_nxt = VC_SETTLE2;
			VC_SETTLE2: state_nxt = VC_IDLE;
			default: state_nxt = VC_IDLE;
		endcase
		if (start)
			state_nxt = VC_PROD;
	end

	always_comb begin
		busy = (state_q != VC_IDLE);
		load = (state_q == VC_LOAD);
		cell_en = (state_q == VC_LOAD) || (state_q == VC_ITER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= VC_IDLE;
			cnt_q <= '0;
			vc_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (load)
				cnt_q <= '0;
			else if (state_q == VC_ITER)
				cnt_q <= cnt_q + {{(CntW-1){1'b0}}, 1'b1};
			// short total time forces a zero cruise velocity
			if (state_q == VC_FIN2)
				vc_q <= (tot <= ShortTMax) ? 32'sd0 : $signed(div_sat(fin_q));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == VC_NUM)
			num_q <= (dist_sh <<< 2) + dist_sh - NumW'(tvi);
		if (state_q == VC_FIN1)
			fin_q <= div_round(cell_out);
	end

	assign cell_in = load ? div_prep(1'b1, num_q, dvs17, '0) : cell_out;

	tvp_div_cell u_cell (
		.clk(clk),
		.arst_n(arst_n),
		.en(cell_en),
		.word_in(cell_in),
		.word_out(cell_out)
	);

	assign vc = vc_q;

endmodule

[design/trapezoid_velocity_profile.sv]
// Trapezoidal motion profile reference. Write initial velocity, distance and
// total time through the write port (index 0, 1, 2), then send query times on
// the query channel; each query returns one position and velocity request on
// the result channel, in order.
// A write to one of these registers starts the cruise velocity computation: one
// divider cell iterates 33 times, and query ready stays low after the last write
// while the velocity is divided out and the derived constants settle.
// Queries run through a pipeline from accept to result valid: three product stages,
// a 36-stage divider row for the velocity (divisor T), three more product stages
// and a second divider row for the position (divisor 1310720). One query is taken
// every cycle while query ready is high.
// When the receiver stalls, a skid register catches one more result, then the
// pipeline freezes and query ready drops until the receiver takes a result.
// Reset clears the configuration registers to zero: velocity 0, distance 0, time 0,
// so every query returns zero position and velocity until configured.
module trapezoid_velocity_profile import tvp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [1:0] wr_index,
	input logic [31:0] wr_data,
	tvp_query_if.sink query,
	tvp_result_if.source result
);

	logic signed [31:0] vi_q, dist_q;
	logic [30:0] tot_q;
	logic signed [63:0] tvi_q, tvc_q;
	logic signed [32:0] vdiff_q;
	logic signed [NumW-1:0] k_cruise_q, k_down_q, k_end_q;
	logic signed [31:0] vc;
	logic busy, start, advance;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [30:0] tu_s1, rem_t_s1, tu_s2, tu_s3, tu_s4;
	seg_t seg_s1, seg_s2, seg_s3, seg_s4, seg_s5, seg_s6;
	logic signed [65:0] p_s2, m1_s5;
	logic signed [63:0] m2_s5;
	logic signed [NumW-1:0] num1_s3, num2_s6;
	logic signed [31:0] v_s4, v_s5, v_s6;
	logic signed [32:0] b2_s4;

	logic c1_valid, c2_valid;
	logic [31:0] c1_quot, c2_quot;
	tag_t c1_tag, c2_tag;

	logic out_valid_q, skid_valid_q;
	logic signed [31:0] out_pos_q, out_vel_q, skid_pos_q, skid_vel_q;
	logic signed [31:0] new_pos, new_vel;
	logic push, pop;

	// configuration
	assign start = wr_en && (wr_index inside {REG_VI, REG_D, REG_T});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vi_q <= '0;
			dist_q <= '0;
			tot_q <= '0;
			tvi_q <= '0;
			tvc_q <= '0;
			vdiff_q <= '0;
			k_cruise_q <= '0;
			k_down_q <= '0;
			k_end_q <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_VI: vi_q <= wr_data;
					REG_D: dist_q <= wr_data;
					REG_T: tot_q <= wr_data[30:0];
					default: ;
				endcase
			end
			tvi_q <= 64'(vi_q) * 64'($signed({1'b0, tot_q}));
			tvc_q <= 64'(vc) * 64'($signed({1'b0, tot_q}));
			vdiff_q <= 33'(vc) - 33'(vi_q);
			k_cruise_q <= NumW'(tvi_q) - NumW'(tvc_q);
			k_down_q <= NumW'(tvi_q) + (NumW'(tvc_q) <<< 3) - NumW'(tvc_q);
			k_end_q <= NumW'(tvi_q) + (NumW'(tvc_q) <<< 4) + NumW'(tvc_q);
		end
	end

	tvp_vc_unit u_vc (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.travel(dist_q),
		.tot(tot_q),
		.tvi(tvi_q),
		.vc(vc),
		.busy(busy)
	);

	assign advance = !skid_valid_q;
	assign query.ready = advance && !busy;

	// segment select
	logic [30:0] tu_in;
	logic [34:0] t10, tt8;
	seg_t seg_in;

	always_comb begin
		tu_in = query.query_time[30:0];
		t10 = {1'b0, tu_in, 3'b0} + {3'b0, tu_in, 1'b0};
		tt8 = {1'b0, tot_q, 3'b0};
		if (query.query_time[31])
			seg_in = SEG_NEG;
		else if (t10 < {4'b0, tot_q})
			seg_in = SEG_UP;
		else if (t10 < tt8)
			seg_in = SEG_CRUISE;
		else if (tu_in < tot_q)
			seg_in = SEG_DOWN;
		else
			seg_in = SEG_END;
	end

	logic [30:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [NumW-1:0] p72;

	always_comb begin
		mul_a = (seg_s1 == SEG_UP) ? tu_s1 : rem_t_s1;
		mul_b = (seg_s1 == SEG_UP) ? vdiff_q : 33'(vc);
		p72 = NumW'(p_s2);
	end

	// velocity after the first divider row
	logic signed [31:0] v_sel;
	logic signed [32:0] b2_sel;

	always_comb begin
		case (c1_tag.seg)
			SEG_UP: begin
				v_sel = $signed(c1_quot);
				b2_sel = 33'($signed(c1_quot)) + 33'(vi_q);
			end
			SEG_CRUISE: begin
				v_sel = vc;
				b2_sel = 33'(vc);
			end
			SEG_DOWN: begin
				v_sel = $signed(c1_quot);
				b2_sel = 33'(vc) + 33'($signed(c1_quot));
			end
			default: begin
				v_sel = '0;
				b2_sel = '0;
			end
		endcase
	end

	logic signed [NumW-1:0] m1w, m2w, num2_sel;

	always_comb begin
		m1w = NumW'(m1_s5);
		m2w = NumW'(m2_s5);
		case (seg_s5)
			SEG_UP: num2_sel = (m1w <<< 3) + (m1w <<< 1);
			SEG_CRUISE: num2_sel = k_cruise_q + (m1w <<< 4) + (m1w <<< 2);
			SEG_DOWN: num2_sel = k_down_q - (m2w <<< 3) + (m1w <<< 3) + (m1w <<< 1);
			SEG_END: num2_sel = k_end_q;
			default: num2_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= query.valid && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= c1_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tu_s1 <= tu_in;
			rem_t_s1 <= tot_q - tu_in;
			seg_s1 <= seg_in;

			p_s2 <= 66'($signed({1'b0, mul_a})) * 66'(mul_b);
			tu_s2 <= tu_s1;
			seg_s2 <= seg_s1;

			num1_s3 <= (seg_s2 == SEG_UP) ? NumW'(tvi_q) + (p72 <<< 3) + (p72 <<< 1)
				: (p72 <<< 2) + p72;
			tu_s3 <= tu_s2;
			seg_s3 <= seg_s2;

			v_s4 <= v_sel;
			b2_s4 <= b2_sel;
			tu_s4 <= c1_tag.val[30:0];
			seg_s4 <= c1_tag.seg;

			m1_s5 <= 66'($signed({1'b0, tu_s4})) * 66'(b2_s4);
			m2_s5 <= 64'($signed({1'b0, tot_q})) * 64'(v_s4);
			v_s5 <= v_s4;
			seg_s5 <= seg_s4;

			num2_s6 <= num2_sel;
			v_s6 <= v_s5;
			seg_s6 <= seg_s5;
		end
	end

	tvp_div_chain u_vel_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.in_valid(valid_s3),
		.num(num1_s3),
		.dvs({5'b0, tot_q}),
		.tag('{val: {1'b0, tu_s3}, seg: seg_s3}),
		.out_valid(c1_valid),
		.quot(c1_quot),
		.out_tag(c1_tag)
	);

	tvp_div_chain u_pos_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.in_valid(valid_s6),
		.num(num2_s6),
		.dvs(PosDiv),
		.tag('{val: v_s6, seg: seg_s6}),
		.out_valid(c2_valid),
		.quot(c2_quot),
		.out_tag(c2_tag)
	);

	// output register plus skid
	assign new_pos = (c2_tag.seg == SEG_NEG) ? 32'sd0 : $signed(c2_quot);
	assign new_vel = $signed(c2_tag.val);
	assign push = advance && c2_valid;
	assign pop = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || pop)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_pos_q <= skid_pos_q;
				out_vel_q <= skid_vel_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_pos_q <= new_pos;
				out_vel_q <= new_vel;
			end else begin
				skid_pos_q <= new_pos;
				skid_vel_q <= new_vel;
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.position_ref = out_pos_q;
	assign result.velocity_ref = out_vel_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy)
		else $error("register write did not start the cruise computation");

	a_short_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && tot_q <= ShortTMax) |-> (vc == 32'sd0))
		else $error("cruise velocity nonzero for short total time");

	a_freeze_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> $stable(valid_s1))
		else $error("pipeline moved while the skid register was full");

endmodule
